>>> sv/htmr_pkg.sv
// Shared types and constants for the handheld console timer.
`default_nettype none
package htmr_pkg;

    // item modes
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // register indexes
    localparam logic [1:0] REG_DIV  = 2'd0;
    localparam logic [1:0] REG_TIMA = 2'd1;
    localparam logic [1:0] REG_TMA  = 2'd2;
    localparam logic [1:0] REG_TAC  = 2'd3;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_TICK,
        OP_WRITE_DIV,
        OP_WRITE_TIMA,
        OP_WRITE_TMA,
        OP_WRITE_TAC,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] reg_sel;
        logic [7:0] wdata;
    } t_cmd;

    // counter period per clock select
    function automatic logic [31:0] period_of(input logic [1:0] sel);
        logic [31:0] p;
        case (sel)
            2'd0:    p = 32'd1024;
            2'd1:    p = 32'd16;
            2'd2:    p = 32'd64;
            default: p = 32'd256;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

>>> sv/htmr_front.sv
// Front end: takes input items and classifies them into commands.
`default_nettype none
module htmr_front (
    input  wire logic          i_valid,
    input  wire logic [1:0]    i_mode,
    input  wire logic [1:0]    i_reg_index,
    input  wire logic [7:0]    i_write_value,
    input  wire logic          i_queue_full,
    output logic               o_stall,
    output logic               o_push,
    output htmr_pkg::t_cmd     o_cmd
);
    import htmr_pkg::*;

    assign o_stall = i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    always_comb begin
        o_cmd.reg_sel = i_reg_index;
        o_cmd.wdata   = i_write_value;
        unique case (i_mode)
            MODE_TICK: begin
                o_cmd.op = OP_TICK;
            end
            MODE_WRITE: begin
                unique case (i_reg_index)
                    REG_DIV:  o_cmd.op = OP_WRITE_DIV;
                    REG_TIMA: o_cmd.op = OP_WRITE_TIMA;
                    REG_TMA:  o_cmd.op = OP_WRITE_TMA;
                    default:  o_cmd.op = OP_WRITE_TAC;
                endcase
            end
            MODE_READ: begin
                o_cmd.op = OP_READ;
            end
            default: begin
                o_cmd.op = OP_NOP;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> sv/htmr_queue.sv
// Short command queue between front and back end.
`default_nettype none
module htmr_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire htmr_pkg::t_cmd i_push_cmd,
    input  wire logic           i_pop,
    output htmr_pkg::t_cmd      o_pop_cmd,
    output logic                o_empty,
    output logic                o_full
);
    import htmr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_pop_cmd = r_slot[r_rd_ptr];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? bump(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? bump(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule
`default_nettype wire

>>> sv/htmr_back.sv
// Back end: timer state, command execution and the result register.
`default_nettype none
module htmr_back #(
    parameter int TICK_CYCLES    = 16,
    parameter int DIVIDER_PERIOD = 256
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cmd_avail,
    input  wire htmr_pkg::t_cmd i_cmd,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_stall,
    output logic [7:0]          o_read_data,
    output logic                o_timer_interrupt
);
    import htmr_pkg::*;

    localparam logic [31:0] TICK_STEP = 32'(TICK_CYCLES);
    localparam logic [31:0] DIV_STEP  = 32'(DIVIDER_PERIOD);

    logic [31:0] r_cycles,  n_cycles;
    logic [31:0] r_div_ref, n_div_ref;
    logic [31:0] r_cnt_ref, n_cnt_ref;
    logic [7:0]  r_div,  n_div;
    logic [7:0]  r_tima, n_tima;
    logic [7:0]  r_tma,  n_tma;
    logic        r_en,   n_en;
    logic [1:0]  r_sel,  n_sel;

    logic        r_out_valid;
    logic [7:0]  r_rdata, n_rdata;
    logic        r_irq,   n_irq;

    logic [31:0] period;
    logic [7:0]  tima_inc;

    // take a command when the result register is free or draining
    assign o_pop = i_cmd_avail && (!r_out_valid || !i_stall);

    assign o_valid           = r_out_valid;
    assign o_read_data       = r_rdata;
    assign o_timer_interrupt = r_irq;

    always_comb begin
        n_cycles  = r_cycles;
        n_div_ref = r_div_ref;
        n_cnt_ref = r_cnt_ref;
        n_div     = r_div;
        n_tima    = r_tima;
        n_tma     = r_tma;
        n_en      = r_en;
        n_sel     = r_sel;
        n_rdata   = 8'h00;
        n_irq     = 1'b0;
        period    = period_of(r_sel);
        tima_inc  = r_tima + 8'd1;

        unique case (i_cmd.op)
            OP_TICK: begin
                n_cycles = r_cycles + TICK_STEP;
                if ((n_cycles - r_div_ref) > DIV_STEP) begin
                    n_div     = r_div + 8'd1;
                    n_div_ref = r_div_ref + DIV_STEP;
                end
                if (r_en && ((n_cycles - r_cnt_ref) > period)) begin
                    n_cnt_ref = r_cnt_ref + period;
                    if (tima_inc == 8'h00) begin
                        n_tima = r_tma;
                        n_irq  = 1'b1;
                    end else begin
                        n_tima = tima_inc;
                    end
                end
            end
            OP_WRITE_DIV: begin
                n_div = 8'h00;
            end
            OP_WRITE_TIMA: begin
                if (i_cmd.wdata == 8'h00) begin
                    n_tima = r_tma;
                    n_irq  = 1'b1;
                end else begin
                    n_tima = i_cmd.wdata;
                end
            end
            OP_WRITE_TMA: begin
                n_tma = i_cmd.wdata;
            end
            OP_WRITE_TAC: begin
                n_en  = i_cmd.wdata[2];
                n_sel = i_cmd.wdata[1:0];
                if ((n_en && !r_en) || (n_sel != r_sel)) begin
                    n_cnt_ref = r_cycles;
                end
            end
            OP_READ: begin
                case (i_cmd.reg_sel)
                    REG_DIV:  n_rdata = r_div;
                    REG_TIMA: n_rdata = r_tima;
                    REG_TMA:  n_rdata = r_tma;
                    default:  n_rdata = {5'b00000, r_en, r_sel};
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycles    <= '0;
            r_div_ref   <= '0;
            r_cnt_ref   <= '0;
            r_div       <= '0;
            r_tima      <= '0;
            r_tma       <= '0;
            r_en        <= 1'b0;
            r_sel       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cycles  <= n_cycles;
                r_div_ref <= n_div_ref;
                r_cnt_ref <= n_cnt_ref;
                r_div     <= n_div;
                r_tima    <= n_tima;
                r_tma     <= n_tma;
                r_en      <= n_en;
                r_sel     <= n_sel;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rdata <= n_rdata;
            r_irq   <= n_irq;
        end
    end

endmodule
`default_nettype wire

>>> sv/handheld_console_timer.sv
// Top level of the handheld console DIV/TIMA/TMA/TAC timer.
//
//   channel   direction  handshake          payload
//   -------   ---------  -----------------  -------------------------------------
//   input     in         i_valid / o_stall  i_mode, i_reg_index, i_write_value
//   result    out        o_valid / i_stall  o_read_data, o_timer_interrupt
//
// One item per cycle sustained while i_stall stays low; every item gives exactly one result.
// An accepted item is written into the two-entry command queue; the back end
// then pops it, executes it and loads the result register. The back end's
// execute step sets the rate.
// Reset (i_rst_n low, synchronous) clears all timer state, the queue and the
// result valid. o_stall rises only when the queue holds two items, which
// happens when i_stall holds a result and the back end cannot drain.
`default_nettype none
module handheld_console_timer #(
    parameter int TICK_CYCLES    = 16,
    parameter int DIVIDER_PERIOD = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_mode,
    input  wire logic [1:0] i_reg_index,
    input  wire logic [7:0] i_write_value,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_read_data,
    output logic            o_timer_interrupt
);
    import htmr_pkg::*;

    // front -> queue
    logic push;
    t_cmd push_cmd;
    // queue -> back
    logic pop;
    t_cmd pop_cmd;
    logic q_empty;
    logic q_full;

    // decode and accept
    htmr_front u_front (
        .i_valid       (i_valid),
        .i_mode        (i_mode),
        .i_reg_index   (i_reg_index),
        .i_write_value (i_write_value),
        .i_queue_full  (q_full),
        .o_stall       (o_stall),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    // decouples acceptance from result backpressure
    htmr_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .i_pop      (pop),
        .o_pop_cmd  (pop_cmd),
        .o_empty    (q_empty),
        .o_full     (q_full)
    );

    // timer state and result register
    htmr_back #(
        .TICK_CYCLES    (TICK_CYCLES),
        .DIVIDER_PERIOD (DIVIDER_PERIOD)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd_avail       (!q_empty),
        .i_cmd             (pop_cmd),
        .o_pop             (pop),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_read_data       (o_read_data),
        .o_timer_interrupt (o_timer_interrupt)
    );

endmodule
`default_nettype wire

>>> bench/tb.sv
// Self-checking bench for the DIV/TIMA/TMA/TAC handheld console timer.
`timescale 1ns / 100ps

module tb;
    import htmr_pkg::*;

    localparam int TICK_CYCLES    = 16;
    localparam int DIVIDER_PERIOD = 256;

    // the fourth mode is unused: the block must leave all state alone
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // TIMA step period per TAC select
    localparam logic [31:0] PERIOD_SEL0 = 32'd1024;
    localparam logic [31:0] PERIOD_SEL1 = 32'd16;
    localparam logic [31:0] PERIOD_SEL2 = 32'd64;
    localparam logic [31:0] PERIOD_SEL3 = 32'd256;

    localparam int IDLE_PCT     = 9;
    localparam int RANDOM_ITEMS = 950;
    localparam int DRAIN_CYCLES = 10;     // leave plenty of margin for the last results
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        logic [1:0] mode;
        logic [1:0] idx;
        logic [7:0] wval;
        bit         calm;   // no gaps on either side while this item is up
        bit         hold;   // marker: sender waits until all results are in
    } t_bus_item;

    typedef struct {
        logic [7:0] read_data;
        logic       irq;
    } t_timer_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [1:0] i_mode = MODE_TICK;
    logic [1:0] i_reg_index = REG_DIV;
    logic [7:0] i_write_value = 8'h00;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_read_data;
    logic       o_timer_interrupt;

    t_bus_item     pending_q[$];
    t_timer_result expected_results_q[$];

    // shadow timer state, updated once per accepted item
    logic [31:0] sh_cycles, sh_div_ref, sh_tima_ref;
    logic [7:0]  sh_div, sh_tima, sh_tma;
    logic        sh_en;
    logic [1:0]  sh_sel;

    bit calm = 1'b0;
    int errors = 0;
    int n_ticks = 0, n_writes = 0, n_reads = 0, n_spare = 0, n_irqs = 0;
    int cycle_no = 0;

    handheld_console_timer #(
        .TICK_CYCLES    (TICK_CYCLES),
        .DIVIDER_PERIOD (DIVIDER_PERIOD)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_mode            (i_mode),
        .i_reg_index       (i_reg_index),
        .i_write_value     (i_write_value),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_read_data       (o_read_data),
        .o_timer_interrupt (o_timer_interrupt)
    );

    always #5 i_clk = ~i_clk;

    // Applies one item to the shadow state and returns the result it must produce.
    function automatic t_timer_result predict_timer_result(input logic [1:0] mode,
                                                           input logic [1:0] idx,
                                                           input logic [7:0] wval);
        t_timer_result r;
        logic [31:0]   per;
        logic [31:0]   since;
        logic          new_en;
        logic [1:0]    new_sel;
        r.read_data = 8'h00;
        r.irq       = 1'b0;
        case (mode)
            MODE_TICK: begin
                sh_cycles = sh_cycles + 32'(TICK_CYCLES);
                since = sh_cycles - sh_div_ref;
                if (since > 32'(DIVIDER_PERIOD)) begin
                    sh_div     = sh_div + 8'd1;
                    sh_div_ref = sh_div_ref + 32'(DIVIDER_PERIOD);
                end
                // TIMA keeps its own reference and only moves while enabled
                if (sh_en) begin
                    case (sh_sel)
                        2'd0:    per = PERIOD_SEL0;
                        2'd1:    per = PERIOD_SEL1;
                        2'd2:    per = PERIOD_SEL2;
                        default: per = PERIOD_SEL3;
                    endcase
                    since = sh_cycles - sh_tima_ref;
                    if (since > per) begin
                        sh_tima     = sh_tima + 8'd1;
                        sh_tima_ref = sh_tima_ref + per;
                        if (sh_tima == 8'h00) begin
                            sh_tima = sh_tma;
                            r.irq   = 1'b1;
                        end
                    end
                end
            end
            MODE_WRITE: begin
                case (idx)
                    REG_DIV: sh_div = 8'h00;
                    REG_TIMA: begin
                        // writing zero behaves like an overflow
                        if (wval == 8'h00) begin
                            sh_tima = sh_tma;
                            r.irq   = 1'b1;
                        end else begin
                            sh_tima = wval;
                        end
                    end
                    REG_TMA: sh_tma = wval;
                    default: begin
                        new_en  = wval[2];
                        new_sel = wval[1:0];
                        if ((new_en && !sh_en) || new_sel != sh_sel)
                            sh_tima_ref = sh_cycles;
                        sh_en  = new_en;
                        sh_sel = new_sel;
                    end
                endcase
            end
            MODE_READ: begin
                case (idx)
                    REG_DIV:  r.read_data = sh_div;
                    REG_TIMA: r.read_data = sh_tima;
                    REG_TMA:  r.read_data = sh_tma;
                    default:  r.read_data = {5'b0, sh_en, sh_sel};
                endcase
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic push_item(input logic [1:0] mode, input logic [1:0] idx,
                             input logic [7:0] wval, input bit calm_item);
        t_bus_item it;
        it.mode = mode;
        it.idx  = idx;
        it.wval = wval;
        it.calm = calm_item;
        it.hold = 1'b0;
        pending_q.push_back(it);
    endtask

    task automatic push_hold();
        t_bus_item it;
        it.mode = MODE_TICK;
        it.idx  = REG_DIV;
        it.wval = 8'h00;
        it.calm = 1'b0;
        it.hold = 1'b1;
        pending_q.push_back(it);
    endtask

    // Driver: accepts at the edge, then picks what to present next.
    // A stalled item stays put; gaps are only inserted once the slot is free.
    always @(posedge i_clk) begin : driver
        t_bus_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_results_q.push_back(
                    predict_timer_result(i_mode, i_reg_index, i_write_value));
                case (i_mode)
                    MODE_TICK:  n_ticks++;
                    MODE_WRITE: n_writes++;
                    MODE_READ:  n_reads++;
                    default:    n_spare++;
                endcase
            end
            if (!i_valid || !o_stall) begin
                if (pending_q.size() != 0 && pending_q[0].hold) begin
                    // pause here until the block has handed back every result
                    i_valid <= 1'b0;
                    if (expected_results_q.size() == 0)
                        pending_q.delete(0);
                end else if (pending_q.size() != 0 &&
                             (pending_q[0].calm || $urandom_range(99) >= IDLE_PCT)) begin
                    nxt = pending_q.pop_front();
                    i_valid       <= 1'b1;
                    i_mode        <= nxt.mode;
                    i_reg_index   <= nxt.idx;
                    i_write_value <= nxt.wval;
                    calm          <= nxt.calm;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure, switched off during the calm stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_stall <= 1'b0;
        else
            i_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
    end

    // Monitor: every accepted result is checked against the oldest prediction.
    always @(posedge i_clk) begin : monitor
        t_timer_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (o_timer_interrupt)
                n_irqs++;
            if (expected_results_q.size() == 0) begin
                $display("%0t: unexpected result read_data=%02h irq=%0b",
                         $time, o_read_data, o_timer_interrupt);
                errors++;
            end else begin
                want = expected_results_q.pop_front();
                if (o_read_data !== want.read_data) begin
                    $display("%0t: read_data expected %02h actual %02h",
                             $time, want.read_data, o_read_data);
                    errors++;
                end
                if (o_timer_interrupt !== want.irq) begin
                    $display("%0t: timer_interrupt expected %0b actual %0b",
                             $time, want.irq, o_timer_interrupt);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_no++;
        if (cycle_no >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still expected, %0d items pending",
                     $time, expected_results_q.size(), pending_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        int         pick;
        logic [1:0] idx;
        logic [7:0] val;
        bit         c;

        sh_cycles   = '0;
        sh_div_ref  = '0;
        sh_tima_ref = '0;
        sh_div      = '0;
        sh_tima     = '0;
        sh_tma      = '0;
        sh_en       = 1'b0;
        sh_sel      = '0;

        // reset values of every register
        push_item(MODE_READ,  REG_DIV,  8'h00, 1'b0);
        push_item(MODE_READ,  REG_TIMA, 8'h00, 1'b0);
        push_item(MODE_READ,  REG_TMA,  8'h00, 1'b0);
        push_item(MODE_READ,  REG_TAC,  8'hFF, 1'b0);
        // zero write to TIMA reloads from TMA and raises the interrupt
        push_item(MODE_WRITE, REG_TMA,  8'hFF, 1'b0);
        push_item(MODE_WRITE, REG_TIMA, 8'h00, 1'b0);
        push_item(MODE_READ,  REG_TIMA, 8'h00, 1'b0);
        // fastest period: TIMA sits at FF, so each step overflows
        push_item(MODE_WRITE, REG_TAC,  8'h05, 1'b0);
        push_item(MODE_TICK,  REG_DIV,  8'h00, 1'b0);
        push_item(MODE_TICK,  REG_TIMA, 8'hFF, 1'b0);
        push_item(MODE_TICK,  REG_TAC,  8'h00, 1'b0);
        push_item(MODE_WRITE, REG_TMA,  8'h00, 1'b0);
        push_item(MODE_TICK,  REG_TMA,  8'h00, 1'b0);
        // DIV write clears whatever the byte
        push_item(MODE_WRITE, REG_DIV,  8'hFF, 1'b0);
        // upper TAC bits ignored; disable plus select change
        push_item(MODE_WRITE, REG_TAC,  8'hFA, 1'b0);
        push_item(MODE_READ,  REG_TAC,  8'h00, 1'b0);
        push_item(MODE_TICK,  REG_DIV,  8'h00, 1'b0);
        push_item(MODE_READ,  REG_TIMA, 8'h00, 1'b0);
        // unused mode leaves state alone
        push_item(MODE_SPARE, REG_TAC,  8'hFF, 1'b0);
        push_item(MODE_SPARE, REG_DIV,  8'h00, 1'b0);
        // enable with an unchanged select, then switch the select while enabled
        push_item(MODE_WRITE, REG_TAC,  8'h00, 1'b0);
        push_item(MODE_WRITE, REG_TAC,  8'h04, 1'b0);
        push_item(MODE_WRITE, REG_TAC,  8'h07, 1'b0);
        push_item(MODE_WRITE, REG_TIMA, 8'hFF, 1'b0);
        push_item(MODE_READ,  REG_TAC,  8'h00, 1'b0);
        push_hold();

        // Random part: tick heavy so DIV and TIMA really step and wrap.
        // TIMA writes lean toward high values to provoke overflows.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            c    = (i >= 350 && i < 550);
            pick = $urandom_range(99);
            idx  = 2'($urandom_range(3));
            val  = 8'($urandom_range(255));
            if (i == 700)
                push_hold();
            if (pick < 55) begin
                push_item(MODE_TICK, idx, val, c);
            end else if (pick < 75) begin
                if (idx == REG_TIMA && $urandom_range(3) != 0)
                    val = ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom_range(255, 240));
                push_item(MODE_WRITE, idx, val, c);
            end else if (pick < 95) begin
                push_item(MODE_READ, idx, val, c);
            end else begin
                push_item(MODE_SPARE, idx, val, c);
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // settle on the falling edge so nothing races the clocked blocks
        do @(negedge i_clk);
        while (pending_q.size() != 0 || i_valid || expected_results_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_results_q.size());
            errors++;
        end

        $display("run covered %0d ticks, %0d writes, %0d reads, %0d unused-mode items",
                 n_ticks, n_writes, n_reads, n_spare);
        $display("%0d timer interrupts seen, %0d mismatches", n_irqs, errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
